[hw/rtl/lpm_pkg.sv]
package lpm_pkg;

    localparam int PATTERN_MAX_DEF  = 32;
    localparam int OFFSET_WIDTH_DEF = 32;

    localparam int LEN_W     = 6;
    localparam int OUT_OFF_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int PAT_BITS  = 256;

    typedef enum logic [1:0] {
        MODE_ALL  = 2'd0,
        MODE_NEXT = 2'd1,
        MODE_PREV = 2'd2,
        MODE_RSVD = 2'd3
    } search_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0      = 3'd0,
        REG_PATTERN_1      = 3'd1,
        REG_PATTERN_2      = 3'd2,
        REG_PATTERN_3      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_CASE_SENSITIVE = 3'd5,
        REG_SEARCH_MODE    = 3'd6,
        REG_START_OFFSET   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic shift_en;
        logic fold_en;
    } cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] pattern_byte(input logic [PAT_BITS-1:0] pat,
                                                input logic [4:0] idx);
        return pat[idx*8 +: 8];
    endfunction

endpackage

[hw/rtl/lpm_cell.sv]
module lpm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpm_pkg::cell_ctrl_t  ctrl,
    input  logic [7:0]           byte_in,
    input  logic [7:0]           pat_byte,
    input  logic                 cmp_en,
    output logic [7:0]           byte_out,
    output logic                 match
);

    logic [7:0] window_reg;
    logic [7:0] window_next;

    assign window_next = ctrl.shift_en ? byte_in : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    assign byte_out = window_reg;
    assign match    = !cmp_en ||
                      (lpm_pkg::fold_byte(window_reg, ctrl.fold_en) ==
                       lpm_pkg::fold_byte(pat_byte, ctrl.fold_en));

endmodule

[hw/rtl/literal_pattern_matcher_unit.sv]
// Streaming literal search: text bytes enter on s_axis at one transfer per cycle with no
// bubbles, since a row of PATTERN_MAX cells holds the most recent bytes and compares them all
// against the pattern in parallel, so overlapping matches are all seen. Each byte's result (if
// any) passes the stage 1 registers and the output register before it is offered on m_axis;
// the input stalls only while a result waits on m_axis and the next byte is held behind it.
// search_mode picks all matches, the first at or after start_offset, or the last before
// start_offset (given with the final byte). The byte marked tlast always yields a result;
// tuser low there means no match is reported with that byte. Write the registers through
// the cfg port only while no byte is in flight; a write applies from the next byte on.
module literal_pattern_matcher_unit #(
    parameter int PATTERN_MAX  = lpm_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_WIDTH = lpm_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // text_byte
    input  logic                          s_axis_tlast,  // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // match_offset, match_length, pad
    output logic                          m_axis_tuser,  // found_flag
    output logic                          m_axis_tlast   // end_of_text
);

    localparam int CMP_W = (OFFSET_WIDTH > lpm_pkg::OUT_OFF_W) ? OFFSET_WIDTH
                                                                : lpm_pkg::OUT_OFF_W;

    logic [3:0][63:0]                  pattern_reg;
    logic [lpm_pkg::LEN_W-1:0]         pattern_length_reg;
    logic                              case_sensitive_reg;
    lpm_pkg::search_mode_t             search_mode_reg;
    logic [lpm_pkg::OUT_OFF_W-1:0]     start_offset_reg;

    logic [OFFSET_WIDTH-1:0]           pos_reg;
    logic [OFFSET_WIDTH-1:0]           pos_next;
    logic                              s1_valid_reg;
    logic [OFFSET_WIDTH-1:0]           s1_pos_reg;
    logic                              s1_last_reg;
    logic                              next_reported_reg;
    logic                              next_reported_next;
    logic [lpm_pkg::OUT_OFF_W-1:0]     held_offset_reg;
    logic [lpm_pkg::OUT_OFF_W-1:0]     held_offset_next;
    logic                              held_valid_reg;
    logic                              held_valid_next;

    logic                              out_valid_reg;
    logic [lpm_pkg::OUT_OFF_W-1:0]     out_offset_reg;
    logic [lpm_pkg::LEN_W-1:0]         out_length_reg;
    logic                              out_found_reg;
    logic                              out_end_reg;

    logic                              in_xfer;
    logic                              adv;
    logic                              s1_take;
    logic [lpm_pkg::LEN_W-1:0]         len;
    logic [lpm_pkg::LEN_W-1:0]         len_m1;
    logic [PATTERN_MAX-1:0]            cell_match;
    logic [PATTERN_MAX-1:0][7:0]       window;
    lpm_pkg::cell_ctrl_t               cell_ctrl;
    logic                              hit;
    logic [OFFSET_WIDTH-1:0]           off;
    logic [CMP_W-1:0]                  off_c;
    logic [CMP_W-1:0]                  start_c;
    logic                              res_valid;
    logic [lpm_pkg::OUT_OFF_W-1:0]     res_offset;
    logic                              res_found;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            pattern_length_reg <= '0;
            case_sensitive_reg <= 1'b1;
            search_mode_reg    <= lpm_pkg::MODE_ALL;
            start_offset_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (lpm_pkg::cfg_reg_t'(cfg_index))
                lpm_pkg::REG_PATTERN_0:      pattern_reg[0] <= cfg_data;
                lpm_pkg::REG_PATTERN_1:      pattern_reg[1] <= cfg_data;
                lpm_pkg::REG_PATTERN_2:      pattern_reg[2] <= cfg_data;
                lpm_pkg::REG_PATTERN_3:      pattern_reg[3] <= cfg_data;
                lpm_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[lpm_pkg::LEN_W-1:0];
                lpm_pkg::REG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                lpm_pkg::REG_SEARCH_MODE:
                    search_mode_reg <= lpm_pkg::search_mode_t'(cfg_data[1:0]);
                lpm_pkg::REG_START_OFFSET:
                    start_offset_reg <= cfg_data[lpm_pkg::OUT_OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s1_take       = s1_valid_reg && adv;

    // cell row
    assign len = (pattern_length_reg > lpm_pkg::LEN_W'(PATTERN_MAX)) ?
                 lpm_pkg::LEN_W'(PATTERN_MAX) : pattern_length_reg;
    assign len_m1 = len - 1'b1;

    assign cell_ctrl.shift_en = in_xfer;
    assign cell_ctrl.fold_en  = !case_sensitive_reg;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic [7:0]                byte_in;
        logic [lpm_pkg::LEN_W-1:0] pat_idx;

        if (i == 0)
        begin : g_head
            assign byte_in = s_axis_tdata;
        end
        else
        begin : g_body
            assign byte_in = window[i-1];
        end

        assign pat_idx = len_m1 - lpm_pkg::LEN_W'(i);

        lpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .byte_in  (byte_in),
            .pat_byte (lpm_pkg::pattern_byte(pattern_reg, pat_idx[4:0])),
            .cmp_en   (lpm_pkg::LEN_W'(i) < len),
            .byte_out (window[i]),
            .match    (cell_match[i])
        );
    end

    // stage 1: position tracking
    always_comb
    begin
        pos_next = pos_reg;
        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                pos_next = '0;
            end
            else if (pos_reg != '1)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pos_reg  <= pos_reg;
            s1_last_reg <= s_axis_tlast;
        end
    end

    // stage 2: match decision and mode filter
    assign hit     = (len != '0) && (s1_pos_reg >= OFFSET_WIDTH'(len_m1)) && (&cell_match);
    assign off     = s1_pos_reg - OFFSET_WIDTH'(len_m1);
    assign off_c   = CMP_W'(off);
    assign start_c = CMP_W'(start_offset_reg);

    always_comb
    begin
        res_valid          = 1'b0;
        res_offset         = '0;
        res_found          = 1'b0;
        next_reported_next = next_reported_reg;
        held_offset_next   = held_offset_reg;
        held_valid_next    = held_valid_reg;
        unique case (search_mode_reg)
            lpm_pkg::MODE_NEXT:
            begin
                if (hit && !next_reported_reg && off_c >= start_c)
                begin
                    res_valid          = 1'b1;
                    res_found          = 1'b1;
                    res_offset         = off_c[lpm_pkg::OUT_OFF_W-1:0];
                    next_reported_next = 1'b1;
                end
                else if (s1_last_reg)
                begin
                    res_valid = 1'b1;
                end
            end
            lpm_pkg::MODE_PREV:
            begin
                if (hit && off_c < start_c)
                begin
                    held_offset_next = off_c[lpm_pkg::OUT_OFF_W-1:0];
                    held_valid_next  = 1'b1;
                end
                if (s1_last_reg)
                begin
                    res_valid  = 1'b1;
                    res_found  = held_valid_next;
                    res_offset = held_valid_next ? held_offset_next : '0;
                end
            end
            default:
            begin
                if (hit)
                begin
                    res_valid  = 1'b1;
                    res_found  = 1'b1;
                    res_offset = off_c[lpm_pkg::OUT_OFF_W-1:0];
                end
                else if (s1_last_reg)
                begin
                    res_valid = 1'b1;
                end
            end
        endcase
        if (s1_last_reg)
        begin
            next_reported_next = 1'b0;
            held_offset_next   = '0;
            held_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_reported_reg <= 1'b0;
            held_offset_reg   <= '0;
            held_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                next_reported_reg <= next_reported_next;
                held_offset_reg   <= held_offset_next;
                held_valid_reg    <= held_valid_next;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_offset_reg <= res_offset;
            out_length_reg <= res_found ? len : '0;
            out_found_reg  <= res_found;
            out_end_reg    <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_length_reg, out_offset_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_end_reg;

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && s1_valid_reg))
        else $error("input stalled without a blocked result");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_last_reg |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final byte produced no result");

    a_pos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tlast |=> (pos_reg == '0))
        else $error("position not cleared after final byte");

    a_not_found_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tlast && m_axis_tdata[37:0] == '0))
        else $error("empty result carries data");

    a_found_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[37:32] != '0))
        else $error("match reported with zero length");

endmodule

[tb/tb_literal_pattern_matcher_unit.sv]
module tb_literal_pattern_matcher_unit;

    localparam int TEXT_BYTES     = 850;
    localparam int SETTLE_CYCLES  = 8;
    localparam int BACKLOG_CYCLES = 300;
    localparam int BACKLOG_PHASE  = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    localparam int CFG_KEEP     = -1;
    localparam int DIR_FOLD     = 0;
    localparam int DIR_NEXT     = 1;
    localparam int DIR_PREV     = 2;
    localparam int DIR_OVERSIZE = 3;
    localparam int DIR_EXACT    = 4;

    typedef struct packed {
        logic [31:0] offset;
        logic [5:0]  length;
        logic        found;
        logic        eot;
    } match_result_t;

    typedef struct packed {
        logic [255:0]          pattern;
        logic [5:0]            length;
        logic                  exact;
        lpm_pkg::search_mode_t mode;
        logic [31:0]           start;
    } search_config_t;

    typedef struct {
        int            cfg_id;
        logic [7:0]    data;
        logic          last;
        bit            typed;
        match_result_t want;
    } text_row_t;

    localparam match_result_t NONE_FOUND = '{32'd0, 6'd0, 1'b0, 1'b1};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    lpm_pkg::cfg_reg_t cfg_index = lpm_pkg::REG_PATTERN_0;
    logic [63:0]       cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    literal_pattern_matcher_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    search_config_t cur_cfg;
    logic [7:0]     text_window [32];
    logic [31:0]    text_pos;
    bit             next_done;
    logic [31:0]    prev_off;
    bit             prev_valid;

    match_result_t  expected_matches [$];
    logic [7:0]     text_bytes [$];
    int             error_count = 0;
    int             bytes_sent = 0;
    bit             tx_idle_on = 1'b1;
    bit             tx_offering = 1'b0;
    logic           rx_idle_on = 1'b1;
    logic           backlog_phase = 1'b0;
    bit             backlog_done = 1'b0;
    int             rx_stall = 0;

    search_config_t directed_cfg [5];

    text_row_t directed_text [20] = '{
        '{CFG_KEEP,     8'hFF, 1'b1, 1'b1, NONE_FOUND},
        '{DIR_FOLD,     "A",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "B",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "B",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "A",   1'b1, 1'b1, '{32'd2, 6'd3, 1'b1, 1'b1}},
        '{DIR_NEXT,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b1, 1'b1, NONE_FOUND},
        '{DIR_PREV,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "a",   1'b1, 1'b1, '{32'd1, 6'd2, 1'b1, 1'b1}},
        '{DIR_OVERSIZE, 8'h00, 1'b0, 1'b0, '0},
        '{CFG_KEEP,     8'h00, 1'b1, 1'b1, NONE_FOUND},
        '{DIR_EXACT,    "a",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "b",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "A",   1'b0, 1'b0, '0},
        '{CFG_KEEP,     "b",   1'b1, 1'b1, '{32'd2, 6'd2, 1'b1, 1'b1}}
    };

    function automatic int unsigned pattern_span();
        return (cur_cfg.length > 6'd32) ? 32 : int'(cur_cfg.length);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (!cur_cfg.exact && c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic void clear_text_state();
        foreach (text_window[i])
        begin
            text_window[i] = 8'h00;
        end
        text_pos   = '0;
        next_done  = 1'b0;
        prev_off   = '0;
        prev_valid = 1'b0;
    endfunction

    function automatic bit scan_text_byte(input logic [7:0] b, input logic last,
                                          output match_result_t res);
        int unsigned span;
        bit          hit;
        bit          emitted;
        logic [31:0] off;
        span = pattern_span();
        for (int i = 31; i > 0; i--)
        begin
            text_window[i] = text_window[i-1];
        end
        text_window[0] = b;
        hit = 1'b0;
        off = '0;
        if (span != 0 && text_pos >= span - 1)
        begin
            hit = 1'b1;
            for (int k = 0; k < span; k++)
            begin
                if (fold_case(cur_cfg.pattern[k*8 +: 8]) != fold_case(text_window[span-1-k]))
                begin
                    hit = 1'b0;
                end
            end
            off = text_pos - (span - 1);
        end
        if (text_pos != 32'hFFFF_FFFF)
        begin
            text_pos++;
        end
        res = '0;
        emitted = 1'b0;
        case (cur_cfg.mode)
            lpm_pkg::MODE_NEXT:
            begin
                if (hit && !next_done && off >= cur_cfg.start)
                begin
                    next_done = 1'b1;
                    res = '{off, 6'(span), 1'b1, last};
                    emitted = 1'b1;
                end
            end
            lpm_pkg::MODE_PREV:
            begin
                if (hit && off < cur_cfg.start)
                begin
                    prev_off   = off;
                    prev_valid = 1'b1;
                end
                if (last && prev_valid)
                begin
                    res = '{prev_off, 6'(span), 1'b1, 1'b1};
                    emitted = 1'b1;
                end
            end
            default:
            begin
                if (hit)
                begin
                    res = '{off, 6'(span), 1'b1, last};
                    emitted = 1'b1;
                end
            end
        endcase
        if (last && !emitted)
        begin
            res = NONE_FOUND;
            emitted = 1'b1;
        end
        if (last)
        begin
            clear_text_state();
        end
        return emitted;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 3))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            default: return 8'h42;
        endcase
    endfunction

    function automatic search_config_t make_search_config(input string p, input int unsigned len,
                                                          input bit exact,
                                                          input lpm_pkg::search_mode_t mode,
                                                          input logic [31:0] start);
        search_config_t c;
        c = '0;
        for (int i = 0; i < p.len(); i++)
        begin
            c.pattern[i*8 +: 8] = p[i];
        end
        c.length = 6'(len);
        c.exact  = exact;
        c.mode   = mode;
        c.start  = start;
        return c;
    endfunction

    function automatic search_config_t random_search_config();
        search_config_t c;
        int             r;
        int             fill;
        for (int k = 0; k < 8; k++)
        begin
            c.pattern[k*32 +: 32] = $urandom;
        end
        fill = $urandom_range(0, 9);
        if (fill == 0)
        begin
            c.pattern = '0;
        end
        else if (fill == 1)
        begin
            c.pattern = '1;
        end
        else if (fill > 3)
        begin
            for (int k = 0; k < 32; k++)
            begin
                c.pattern[k*8 +: 8] = pick_letter();
            end
        end
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            c.length = 6'd0;
        end
        else if (r == 1)
        begin
            c.length = 6'd32;
        end
        else if (r == 2)
        begin
            c.length = 6'($urandom_range(33, 63));
        end
        else if (r < 6)
        begin
            c.length = 6'($urandom_range(5, 31));
        end
        else
        begin
            c.length = 6'($urandom_range(1, 4));
        end
        c.exact = 1'($urandom_range(0, 1));
        c.mode  = lpm_pkg::search_mode_t'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            c.start = 32'd0;
        end
        else if (r == 1)
        begin
            c.start = 32'hFFFF_FFFF;
        end
        else if (r == 2)
        begin
            c.start = $urandom;
        end
        else
        begin
            c.start = $urandom_range(0, 40);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        end
    endtask

    task automatic check_match_result();
        match_result_t want;
        if (expected_matches.size() == 0)
        begin
            report_mismatch("result with none pending, tdata", 64'(m_axis_tdata), 64'd0);
            return;
        end
        want = expected_matches.pop_front();
        if (m_axis_tdata[31:0] != want.offset)
        begin
            report_mismatch("match_offset", 64'(m_axis_tdata[31:0]), 64'(want.offset));
        end
        if (m_axis_tdata[37:32] != want.length)
        begin
            report_mismatch("match_length", 64'(m_axis_tdata[37:32]), 64'(want.length));
        end
        if (m_axis_tdata[39:38] != 2'b00)
        begin
            report_mismatch("tdata padding", 64'(m_axis_tdata[39:38]), 64'd0);
        end
        if (m_axis_tuser != want.found)
        begin
            report_mismatch("found_flag", 64'(m_axis_tuser), 64'(want.found));
        end
        if (m_axis_tlast != want.eot)
        begin
            report_mismatch("end_of_text", 64'(m_axis_tlast), 64'(want.eot));
        end
    endtask

    task automatic write_register(input lpm_pkg::cfg_reg_t idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_search_config(input search_config_t c);
        write_register(lpm_pkg::REG_PATTERN_0, c.pattern[63:0]);
        write_register(lpm_pkg::REG_PATTERN_1, c.pattern[127:64]);
        write_register(lpm_pkg::REG_PATTERN_2, c.pattern[191:128]);
        write_register(lpm_pkg::REG_PATTERN_3, c.pattern[255:192]);
        write_register(lpm_pkg::REG_PATTERN_LENGTH, 64'(c.length));
        write_register(lpm_pkg::REG_CASE_SENSITIVE, 64'(c.exact));
        write_register(lpm_pkg::REG_SEARCH_MODE, 64'(c.mode));
        write_register(lpm_pkg::REG_START_OFFSET, 64'(c.start));
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_text_byte(input logic [7:0] b, input logic last, input bit typed,
                                  input match_result_t want);
        match_result_t res;
        bit            has_result;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        tx_offering = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        has_result = scan_text_byte(b, last, res);
        if (typed)
        begin
            expected_matches.push_back(want);
        end
        else if (has_result)
        begin
            expected_matches.push_back(res);
        end
        bytes_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    task automatic drain_results(input bit settle);
        if (tx_offering)
        begin
            s_axis_tvalid <= 1'b0;
            tx_offering = 1'b0;
        end
        while (expected_matches.size() != 0)
        begin
            @(posedge clk);
        end
        if (settle)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic compose_text();
        int unsigned span;
        int unsigned target;
        int unsigned cut;
        int          sel;
        int          pick;
        logic [7:0]  b;
        span = pattern_span();
        text_bytes.delete();
        target = $urandom_range(1, 12);
        if ($urandom_range(0, 4) < 3)
        begin
            target += span * $urandom_range(1, 3);
        end
        while (text_bytes.size() < target)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                cut = (sel == 3 && span != 0) ? $urandom_range(0, span - 1) : span;
                for (int k = 0; k < cut; k++)
                begin
                    b = cur_cfg.pattern[k*8 +: 8];
                    if ($urandom_range(0, 3) == 0 && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A)
                    begin
                        b ^= 8'h20;
                    end
                    text_bytes.push_back(b);
                end
            end
            if (sel >= 3 && sel < 8)
            begin
                pick = $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 0)
                begin
                    text_bytes.push_back(pick_letter());
                end
                else
                begin
                    text_bytes.push_back(cur_cfg.pattern[pick*8 +: 8]);
                end
            end
            else if (sel >= 8)
            begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_match_result();
        end
        if (backlog_phase && !backlog_done)
        begin
            backlog_done = 1'b1;
            rx_stall = BACKLOG_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall != 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_stall = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int phase;
        int n_texts;
        cur_cfg = '0;
        cur_cfg.exact = 1'b1;
        cur_cfg.mode  = lpm_pkg::MODE_ALL;
        clear_text_state();
        directed_cfg[DIR_FOLD]     = make_search_config("aba", 3, 1'b0, lpm_pkg::MODE_ALL,
                                                        32'd0);
        directed_cfg[DIR_NEXT]     = make_search_config("aa", 2, 1'b1, lpm_pkg::MODE_NEXT,
                                                        32'd1);
        directed_cfg[DIR_PREV]     = make_search_config("aa", 2, 1'b1, lpm_pkg::MODE_PREV,
                                                        32'd2);
        directed_cfg[DIR_OVERSIZE] = make_search_config("", 63, 1'b1, lpm_pkg::MODE_RSVD,
                                                        32'hFFFF_FFFF);
        directed_cfg[DIR_EXACT]    = make_search_config("Ab", 2, 1'b1, lpm_pkg::MODE_ALL,
                                                        32'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_text[i])
        begin
            if (directed_text[i].cfg_id != CFG_KEEP)
            begin
                drain_results(1'b1);
                load_search_config(directed_cfg[directed_text[i].cfg_id]);
            end
            send_text_byte(directed_text[i].data, directed_text[i].last,
                           directed_text[i].typed, directed_text[i].want);
        end

        phase = 0;
        while (bytes_sent < TEXT_BYTES)
        begin
            drain_results(1'b1);
            if (phase == BACKLOG_PHASE)
            begin
                // hold the sender busy while the receiver stalls
                load_search_config(make_search_config("a", 1, 1'b0, lpm_pkg::MODE_ALL, 32'd0));
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
                backlog_phase <= 1'b1;
                n_texts = 6;
            end
            else
            begin
                load_search_config(random_search_config());
                tx_idle_on = ($urandom_range(0, 2) != 0);
                rx_idle_on <= ($urandom_range(0, 2) != 0);
                backlog_phase <= 1'b0;
                n_texts = $urandom_range(2, 6);
            end
            repeat (n_texts)
            begin
                compose_text();
                foreach (text_bytes[i])
                begin
                    send_text_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    drain_results(1'b0);
                end
            end
            phase++;
        end

        drain_results(1'b1);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cell.sv
hw/rtl/literal_pattern_matcher_unit.sv
tb/tb_literal_pattern_matcher_unit.sv
